[design/csw_pkg.sv]
package csw_pkg;

  localparam int MAX_WAITERS = 16;
  localparam int MAX_THREADS = 64;

  localparam int TID_W   = 6;
  localparam int PICK_W  = 16;
  localparam int COUNT_W = 16;
  localparam int IDX_W   = $clog2(MAX_WAITERS);
  localparam int CNT_W   = $clog2(MAX_WAITERS + 1);
  localparam int DIV_W   = IDX_W + 1;
  localparam int STEP_W  = $clog2(PICK_W);

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(PICK_W - 1);
  localparam logic [CNT_W-1:0]  WAIT_FULL = CNT_W'(MAX_WAITERS);

  localparam logic signed [COUNT_W-1:0] COUNT_MIN = {1'b1, {(COUNT_W-1){1'b0}}};
  localparam logic signed [COUNT_W-1:0] COUNT_MAX = {1'b0, {(COUNT_W-1){1'b1}}};

  localparam logic OP_WAIT   = 1'b0;
  localparam logic OP_SIGNAL = 1'b1;

  typedef struct packed {
    logic accept;
    logic exec;
    logic mod_step;
    logic rd_sel;
    logic get_sel;
    logic rd_next;
    logic wr_shift;
    logic finish_wake;
    logic load_out;
  } csw_cmd_t;

  typedef struct packed {
    logic is_signal;
    logic has_waiters;
    logic mod_last;
    logic shift_more;
    logic out_free;
  } csw_sts_t;

endpackage

[design/csw_ctrl.sv]
module csw_ctrl import csw_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  csw_sts_t sts_i,
  output csw_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_MOD   = 3'd2;
  localparam logic [2:0] S_RDSEL = 3'd3;
  localparam logic [2:0] S_GET   = 3'd4;
  localparam logic [2:0] S_SHRD  = 3'd5;
  localparam logic [2:0] S_SHWR  = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (sts_i.is_signal && sts_i.has_waiters) begin
          state_d = S_MOD;
        end else begin
          state_d = S_FIN;
        end
      end
      S_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_last) begin
          state_d = S_RDSEL;
        end
      end
      S_RDSEL: begin
        cmd_o.rd_sel = 1'b1;
        state_d      = S_GET;
      end
      S_GET: begin
        cmd_o.get_sel = 1'b1;
        state_d       = S_SHRD;
      end
      S_SHRD: begin
        if (sts_i.shift_more) begin
          cmd_o.rd_next = 1'b1;
          state_d       = S_SHWR;
        end else begin
          cmd_o.finish_wake = 1'b1;
          state_d           = S_FIN;
        end
      end
      S_SHWR: begin
        cmd_o.wr_shift = 1'b1;
        state_d        = S_SHRD;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

[design/csw_dp.sv]
module csw_dp import csw_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic signed [COUNT_W-1:0] cfg_wdata_i,
  input  logic                      opcode_i,
  input  logic [TID_W-1:0]          thread_id_i,
  input  logic [PICK_W-1:0]         pick_i,
  input  csw_cmd_t                  cmd_i,
  output csw_sts_t                  sts_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      blocked_o,
  output logic                      woken_valid_o,
  output logic [TID_W-1:0]          woken_id_o,
  output logic signed [COUNT_W-1:0] count_after_o,
  output logic [CNT_W-1:0]          waiters_after_o,
  output logic                      error_o
);

  logic                      op_q;
  logic [TID_W-1:0]          tid_q;
  logic [PICK_W-1:0]         pick_q;
  logic signed [COUNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0]          total_q, total_d;
  logic [IDX_W-1:0]          rem_q;
  logic [STEP_W-1:0]         step_q;
  logic [IDX_W-1:0]          idx_q;
  logic                      res_blocked_q, res_wv_q, res_err_q;
  logic [TID_W-1:0]          res_wid_q;
  logic                      out_valid_q;
  logic                      out_blocked_q, out_wv_q, out_err_q;
  logic [TID_W-1:0]          out_wid_q;
  logic signed [COUNT_W-1:0] out_count_q;
  logic [CNT_W-1:0]          out_total_q;

  logic [TID_W-1:0] mem [MAX_WAITERS];
  logic [TID_W-1:0] rd_data_q;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic [TID_W-1:0] wr_data;
  logic             wr_en;

  logic             tid_bad;
  logic             wait_err, wait_blk, sig_err;
  logic [DIV_W-1:0] div_t;
  logic             div_ge;
  logic [IDX_W-1:0] rem_next;
  logic [CNT_W-1:0] idx_next;

  // wait and signal decisions
  assign tid_bad = int'(tid_q) >= MAX_THREADS;

  always_comb begin
    wait_err = 1'b0;
    wait_blk = 1'b0;
    sig_err  = 1'b0;
    if (op_q == OP_WAIT) begin
      if (tid_bad || count_q == COUNT_MIN) begin
        wait_err = 1'b1;
      end else if (count_q <= $signed({COUNT_W{1'b0}})) begin
        if (total_q >= WAIT_FULL) begin
          wait_err = 1'b1;
        end else begin
          wait_blk = 1'b1;
        end
      end
    end else begin
      sig_err = (count_q == COUNT_MAX);
    end
  end

  always_comb begin
    count_d = count_q;
    total_d = total_q;
    if (cfg_we_i) begin
      count_d = cfg_wdata_i;
      total_d = '0;
    end else if (cmd_i.exec) begin
      if (op_q == OP_WAIT) begin
        if (!wait_err) begin
          count_d = count_q - 1'b1;
        end
        if (wait_blk) begin
          total_d = total_q + 1'b1;
        end
      end else if (!sig_err) begin
        count_d = count_q + 1'b1;
      end
    end else if (cmd_i.finish_wake) begin
      total_d = total_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      total_q <= '0;
    end else begin
      count_q <= count_d;
      total_q <= total_d;
    end
  end

  // restoring remainder, one pick bit per step
  assign div_t    = {rem_q, pick_q[PICK_W-1]};
  assign div_ge   = div_t >= DIV_W'(total_q);
  assign rem_next = div_ge ? IDX_W'(div_t - DIV_W'(total_q)) : IDX_W'(div_t);
  assign idx_next = CNT_W'(idx_q) + 1'b1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= opcode_i;
      tid_q  <= thread_id_i;
      pick_q <= pick_i;
    end else if (cmd_i.mod_step) begin
      pick_q <= {pick_q[PICK_W-2:0], 1'b0};
    end
    if (cmd_i.exec) begin
      rem_q  <= '0;
      step_q <= '0;
    end else if (cmd_i.mod_step) begin
      rem_q  <= rem_next;
      step_q <= step_q + 1'b1;
    end
    if (cmd_i.get_sel) begin
      idx_q <= rem_q;
    end else if (cmd_i.wr_shift) begin
      idx_q <= IDX_W'(idx_next);
    end
  end

  // result of the current item
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_blocked_q <= wait_blk;
      res_err_q     <= (op_q == OP_WAIT) ? wait_err : sig_err;
      res_wv_q      <= 1'b0;
      res_wid_q     <= '0;
    end else begin
      if (cmd_i.get_sel) begin
        res_wid_q <= rd_data_q;
      end
      if (cmd_i.finish_wake) begin
        res_wv_q <= 1'b1;
      end
    end
  end

  // waiter list storage
  assign rd_addr = cmd_i.rd_sel  ? rem_q :
                   cmd_i.rd_next ? IDX_W'(idx_next) : idx_q;
  assign wr_en   = (cmd_i.exec && wait_blk) || cmd_i.wr_shift;
  assign wr_addr = cmd_i.wr_shift ? idx_q : IDX_W'(total_q);
  assign wr_data = cmd_i.wr_shift ? rd_data_q : tid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= mem[rd_addr];
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_blocked_q <= res_blocked_q;
      out_wv_q      <= res_wv_q;
      out_wid_q     <= res_wid_q;
      out_err_q     <= res_err_q;
      out_count_q   <= count_q;
      out_total_q   <= total_q;
    end
  end

  assign sts_o.is_signal   = (op_q == OP_SIGNAL);
  assign sts_o.has_waiters = (total_q != '0);
  assign sts_o.mod_last    = (step_q == STEP_LAST);
  assign sts_o.shift_more  = (idx_next < total_q);
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign blocked_o       = out_blocked_q;
  assign woken_valid_o   = out_wv_q;
  assign woken_id_o      = out_wid_q;
  assign count_after_o   = out_count_q;
  assign waiters_after_o = out_total_q;
  assign error_o         = out_err_q;

endmodule

[design/counting_semaphore_waiter_list.sv]
// channel   direction  handshake               payload
// in        input      in_valid_i / in_ready_o  opcode_i, thread_id_i, pick_i
// out       output     out_valid_o / out_ready_i blocked_o, woken_valid_o, woken_id_o,
//                                               count_after_o, waiters_after_o, error_o
// cfg       input      cfg_we_i                cfg_wdata_i (initial_count)
//
// one item at a time; a wait or a signal with no waiters goes from exec straight to the result
// a signal with waiters first works out pick_i mod the waiter count bit-serially, one pick bit per step,
// then reads the chosen entry and moves each later list entry down by one, with a read and a write for each
// reset and cfg writes load the count and empty the list
// a finished result waits in the output register; the next transfer in is taken meanwhile
module counting_semaphore_waiter_list import csw_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic signed [COUNT_W-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      opcode_i,
  input  logic [TID_W-1:0]          thread_id_i,
  input  logic [PICK_W-1:0]         pick_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      blocked_o,
  output logic                      woken_valid_o,
  output logic [TID_W-1:0]          woken_id_o,
  output logic signed [COUNT_W-1:0] count_after_o,
  output logic [CNT_W-1:0]          waiters_after_o,
  output logic                      error_o
);

  csw_cmd_t cmd;
  csw_sts_t sts;

  csw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  csw_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .opcode_i        (opcode_i),
    .thread_id_i     (thread_id_i),
    .pick_i          (pick_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .blocked_o       (blocked_o),
    .woken_valid_o   (woken_valid_o),
    .woken_id_o      (woken_id_o),
    .count_after_o   (count_after_o),
    .waiters_after_o (waiters_after_o),
    .error_o         (error_o)
  );

  a_waiters_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (waiters_after_o <= WAIT_FULL))
    else $error("waiter count above list size");

  a_block_xor_wake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(blocked_o && woken_valid_o))
    else $error("item both blocked and woke a waiter");

  a_block_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && blocked_o) |-> (!error_o && count_after_o < 0))
    else $error("blocked result with error or non-negative count");

  a_wake_id_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !woken_valid_o) |-> (woken_id_o == '0))
    else $error("woken id set without a wake");

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
  import csw_pkg::*;

  typedef struct packed {
    logic               blocked;
    logic               woken_valid;
    logic [TID_W-1:0]   woken_id;
    logic [COUNT_W-1:0] count_after;
    logic [CNT_W-1:0]   waiters_after;
    logic               error;
  } sem_result_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  logic signed [COUNT_W-1:0] cfg_wdata_i = '0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic                      opcode_i = OP_WAIT;
  logic [TID_W-1:0]          thread_id_i = '0;
  logic [PICK_W-1:0]         pick_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic                      blocked_o;
  logic                      woken_valid_o;
  logic [TID_W-1:0]          woken_id_o;
  logic signed [COUNT_W-1:0] count_after_o;
  logic [CNT_W-1:0]          waiters_after_o;
  logic                      error_o;

  // semaphore state as the block should hold it
  logic signed [COUNT_W-1:0] sem_count = '0;
  logic [TID_W-1:0]          waiter_ids[$];
  sem_result_t               pending_results[$];

  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;

  counting_semaphore_waiter_list dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .thread_id_i    (thread_id_i),
    .pick_i         (pick_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .blocked_o      (blocked_o),
    .woken_valid_o  (woken_valid_o),
    .woken_id_o     (woken_id_o),
    .count_after_o  (count_after_o),
    .waiters_after_o(waiters_after_o),
    .error_o        (error_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic sem_result_t predict_op(input logic op, input logic [TID_W-1:0] tid,
                                             input logic [PICK_W-1:0] pk);
    sem_result_t r;
    int sel;
    r = '0;
    if (op == OP_WAIT) begin
      if (sem_count == COUNT_MIN) begin
        r.error = 1'b1;
      end else if (sem_count <= 0) begin
        if (waiter_ids.size() >= MAX_WAITERS) begin
          r.error = 1'b1;
        end else begin
          sem_count = sem_count - 16'sd1;
          waiter_ids.push_back(tid);
          r.blocked = 1'b1;
        end
      end else begin
        sem_count = sem_count - 16'sd1;
      end
    end else begin
      if (sem_count == COUNT_MAX) begin
        r.error = 1'b1;
      end else begin
        sem_count = sem_count + 16'sd1;
      end
      if (waiter_ids.size() != 0) begin
        sel = int'(pk) % waiter_ids.size();
        r.woken_valid = 1'b1;
        r.woken_id = waiter_ids[sel];
        waiter_ids.delete(sel);
      end
    end
    r.count_after = sem_count;
    r.waiters_after = CNT_W'(waiter_ids.size());
    return r;
  endfunction

  function automatic string fmt_result(input sem_result_t r);
    return $sformatf("blocked=%0b woken=%0b/%0d count=%0d waiters=%0d error=%0b",
                     r.blocked, r.woken_valid, r.woken_id, $signed(r.count_after),
                     r.waiters_after, r.error);
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic issue_op(input logic op, input logic [TID_W-1:0] tid,
                          input logic [PICK_W-1:0] pk);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    opcode_i    <= op;
    thread_id_i <= tid;
    pick_i      <= pk;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(predict_op(op, tid, pk));
  endtask

  task automatic drain_results(input int settle);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic set_initial_count(input logic signed [COUNT_W-1:0] value);
    drain_results(4);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    sem_count = value;
    waiter_ids.delete();
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_random_ops(input int n_ops);
    int wait_pct;
    logic op;
    logic [PICK_W-1:0] pk;
    wait_pct = 50;
    for (int i = 0; i < n_ops; i++) begin
      // bursts of mostly waits, mostly signals or an even mix fill and empty the list
      if (i % 16 == 0) wait_pct = 20 + 30 * $urandom_range(2);
      op = ($urandom_range(99) < wait_pct) ? OP_WAIT : OP_SIGNAL;
      pk = ($urandom_range(2) == 0) ? PICK_W'($urandom_range(40)) : PICK_W'($urandom);
      issue_op(op, TID_W'($urandom_range(MAX_THREADS - 1)), pk);
    end
  endtask

  task automatic test_directed_basic();
    set_initial_count(16'sd0);
    issue_op(OP_WAIT, 6'd0, 16'h0000);
    issue_op(OP_WAIT, 6'd63, 16'h0000);
    issue_op(OP_SIGNAL, 6'd0, 16'hFFFF);
    issue_op(OP_SIGNAL, 6'd0, 16'h0000);
    issue_op(OP_SIGNAL, 6'd0, 16'h8000);
  endtask

  task automatic test_full_list();
    set_initial_count(-16'sd1);
    for (int i = 0; i < MAX_WAITERS; i++) issue_op(OP_WAIT, TID_W'(i * 4 + 3), 16'h0000);
    issue_op(OP_WAIT, 6'd21, 16'h0000);
    issue_op(OP_SIGNAL, 6'd0, 16'hFFFF);
    issue_op(OP_SIGNAL, 6'd0, 16'h0007);
  endtask

  task automatic test_count_limits();
    set_initial_count(COUNT_MAX);
    issue_op(OP_SIGNAL, 6'd0, 16'h0000);
    set_initial_count(COUNT_MIN);
    issue_op(OP_WAIT, 6'd42, 16'h0000);
    issue_op(OP_SIGNAL, 6'd0, 16'hFFFF);
    issue_op(OP_WAIT, 6'd1, 16'h0000);
  endtask

  task automatic test_random_no_idle();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_initial_count(16'sd0);
    run_random_ops(110);
  endtask

  task automatic test_random_sender_idle();
    send_idle_pct = 56;
    recv_stall_pct = 0;
    set_initial_count(COUNT_W'($urandom));
    run_random_ops(110);
  endtask

  task automatic test_random_receiver_stall();
    send_idle_pct = 0;
    recv_stall_pct = 56;
    set_initial_count(16'sd32760);
    run_random_ops(110);
  endtask

  task automatic test_random_both_idle();
    send_idle_pct = 34;
    recv_stall_pct = 34;
    set_initial_count(-16'sd4);
    run_random_ops(110);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_initial_count(-16'sd2);
    @(posedge clk_i);
    hold_request = 300;
    run_random_ops(24);
    drain_results(0);
    run_random_ops(16);
  endtask

  always @(negedge clk_i) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    sem_result_t got;
    sem_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.blocked       = blocked_o;
      got.woken_valid   = woken_valid_o;
      got.woken_id      = woken_id_o;
      got.count_after   = count_after_o;
      got.waiters_after = waiters_after_o;
      got.error         = error_o;
      if (pending_results.size() == 0) begin
        note_mismatch({"result with nothing pending: ", fmt_result(got)});
      end else begin
        want = pending_results.pop_front();
        if (got.blocked !== want.blocked || got.woken_valid !== want.woken_valid ||
            got.woken_id !== want.woken_id || got.count_after !== want.count_after ||
            got.waiters_after !== want.waiters_after || got.error !== want.error)
          note_mismatch({"expected ", fmt_result(want), " got ", fmt_result(got)});
      end
    end
  end

  initial begin
    #(5_000_000);
    $display("counting_semaphore_waiter_list test failed");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed_basic();
    test_full_list();
    test_count_limits();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();
    test_backpressure();
    drain_results(60);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("counting_semaphore_waiter_list test passed");
    end else begin
      $display("counting_semaphore_waiter_list test failed");
    end
    $finish;
  end

endmodule
